/* rtl/ttsc_pkg.sv */
package ttsc_pkg;

    // Time base width; all time differences wrap at this width.
    localparam int TIME_BITS = 32;

    localparam int NOW_W  = 32;
    localparam int DIST_W = 12;
    localparam int HOLD_W = 16;
    localparam int DUTY_W = 8;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_SEARCH_ROTATE = DUTY_W'(150);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [0:0] {
        KIND_EVAL    = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD   = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_ATTACK   = 3'd0,
        MODE_APPROACH = 3'd1,
        MODE_TRACK_L  = 3'd2,
        MODE_TRACK_R  = 3'd3,
        MODE_SEARCH   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    // Search pattern phase, one-hot.
    typedef enum logic [1:0] {
        PH_FWD = 2'b01,
        PH_ROT = 2'b10
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_RANGE = 3'd0,
        REG_HOLD_TIME    = 3'd1,
        REG_SEARCH_FWD   = 3'd2,
        REG_SEARCH_ROT   = 3'd3,
        REG_DUTY_ATTACK  = 3'd4,
        REG_DUTY_APPR    = 3'd5,
        REG_DUTY_TRACK   = 3'd6,
        REG_DUTY_SEARCH  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DIST_W-1:0] strike_range_cm;
        logic [HOLD_W-1:0] hold_time_ms;
        logic [HOLD_W-1:0] search_forward_ms;
        logic [HOLD_W-1:0] search_rotate_ms;
        logic [DUTY_W-1:0] duty_attack;
        logic [DUTY_W-1:0] duty_approach;
        logic [DUTY_W-1:0] duty_track;
        logic [DUTY_W-1:0] duty_search;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [NOW_W-1:0]  now_ms;
        logic              left_seen;
        logic              right_seen;
        logic [DIST_W-1:0] left_dist_cm;
        logic [DIST_W-1:0] right_dist_cm;
    } t_item;

    typedef struct packed {
        logic              emit;
        logic [CMD_W-1:0]  drive_cmd;
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
    } t_res;

endpackage

/* rtl/ttsc_in_if.sv */
interface ttsc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ttsc_pkg::NOW_W-1:0]    now_ms;
    logic                          left_seen;
    logic                          right_seen;
    logic [ttsc_pkg::DIST_W-1:0]   left_dist_cm;
    logic [ttsc_pkg::DIST_W-1:0]   right_dist_cm;

    modport source (
        output valid, kind, now_ms, left_seen, right_seen, left_dist_cm, right_dist_cm,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, left_seen, right_seen, left_dist_cm, right_dist_cm,
        output ready
    );
endinterface

/* rtl/ttsc_out_if.sv */
interface ttsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ttsc_pkg::CMD_W-1:0]    drive_cmd;
    logic [ttsc_pkg::DUTY_W-1:0]   duty;
    logic [ttsc_pkg::MODE_W-1:0]   mode;

    modport source (
        output valid, drive_cmd, duty, mode,
        input  ready
    );
    modport sink (
        input  valid, drive_cmd, duty, mode,
        output ready
    );
endinterface

/* rtl/ttsc_cfg.sv */
module ttsc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output ttsc_pkg::t_cfg                    o_cfg
);

    ttsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strike_range_cm   <= ttsc_pkg::DIST_W'(30);
            r_cfg.hold_time_ms      <= ttsc_pkg::HOLD_W'(500);
            r_cfg.search_forward_ms <= ttsc_pkg::HOLD_W'(800);
            r_cfg.search_rotate_ms  <= ttsc_pkg::HOLD_W'(600);
            r_cfg.duty_attack       <= ttsc_pkg::DUTY_W'(255);
            r_cfg.duty_approach     <= ttsc_pkg::DUTY_W'(180);
            r_cfg.duty_track        <= ttsc_pkg::DUTY_W'(150);
            r_cfg.duty_search       <= ttsc_pkg::DUTY_W'(120);
        end else if (i_cfg_we) begin
            case (ttsc_pkg::t_reg_idx'(i_cfg_idx))
                ttsc_pkg::REG_ATTACK_RANGE:
                    r_cfg.strike_range_cm <= i_cfg_wdata[ttsc_pkg::DIST_W-1:0];
                ttsc_pkg::REG_HOLD_TIME:   r_cfg.hold_time_ms      <= i_cfg_wdata;
                ttsc_pkg::REG_SEARCH_FWD:  r_cfg.search_forward_ms <= i_cfg_wdata;
                ttsc_pkg::REG_SEARCH_ROT:  r_cfg.search_rotate_ms  <= i_cfg_wdata;
                ttsc_pkg::REG_DUTY_ATTACK:
                    r_cfg.duty_attack   <= i_cfg_wdata[ttsc_pkg::DUTY_W-1:0];
                ttsc_pkg::REG_DUTY_APPR:
                    r_cfg.duty_approach <= i_cfg_wdata[ttsc_pkg::DUTY_W-1:0];
                ttsc_pkg::REG_DUTY_TRACK:
                    r_cfg.duty_track    <= i_cfg_wdata[ttsc_pkg::DUTY_W-1:0];
                ttsc_pkg::REG_DUTY_SEARCH:
                    r_cfg.duty_search   <= i_cfg_wdata[ttsc_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ttsc_eval.sv */
module ttsc_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  ttsc_pkg::t_item   i_item,
    input  ttsc_pkg::t_cfg    i_cfg,
    output ttsc_pkg::t_res    o_res
);

    ttsc_pkg::t_phase r_phase, n_phase;
    ttsc_pkg::t_time  r_phase_start, n_phase_start;
    ttsc_pkg::t_time  r_last_sight, n_last_sight;
    ttsc_pkg::t_side  r_side, n_side;
    logic             r_centered, n_centered;
    logic             r_close, n_close;

    ttsc_pkg::t_time  w_now;
    ttsc_pkg::t_time  w_since_sight;
    ttsc_pkg::t_time  w_elapsed;
    logic             w_in_hold;
    ttsc_pkg::t_res   w_res;

    assign w_now         = ttsc_pkg::TIME_BITS'(i_item.now_ms);
    assign w_since_sight = w_now - r_last_sight;
    assign w_elapsed     = w_now - r_phase_start;
    // A last sighting of zero reads as never seen.
    assign w_in_hold = (r_last_sight != '0)
                    && (w_since_sight < ttsc_pkg::TIME_BITS'(i_cfg.hold_time_ms));

    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_last_sight  = r_last_sight;
        n_side        = r_side;
        n_centered    = r_centered;
        n_close       = r_close;
        w_res.emit      = 1'b1;
        w_res.drive_cmd = ttsc_pkg::CMD_FWD;
        w_res.duty      = i_cfg.duty_search;
        w_res.mode      = ttsc_pkg::MODE_SEARCH;

        if (i_item.kind == ttsc_pkg::KIND_RESTART) begin
            n_phase       = ttsc_pkg::PH_FWD;
            n_phase_start = w_now;
            w_res.emit    = 1'b0;
        end else if (i_item.left_seen || i_item.right_seen) begin
            n_last_sight  = w_now;
            n_phase       = ttsc_pkg::PH_FWD;
            n_phase_start = w_now;
            if (i_item.left_seen && i_item.right_seen) begin
                n_centered = 1'b1;
                n_close    = (i_item.left_dist_cm < i_cfg.strike_range_cm)
                          && (i_item.right_dist_cm < i_cfg.strike_range_cm);
                // Ties count as right.
                n_side = (i_item.left_dist_cm < i_item.right_dist_cm)
                       ? ttsc_pkg::SIDE_LEFT : ttsc_pkg::SIDE_RIGHT;
                w_res.drive_cmd = ttsc_pkg::CMD_FWD;
                w_res.duty = n_close ? i_cfg.duty_attack : i_cfg.duty_approach;
                w_res.mode = n_close ? ttsc_pkg::MODE_ATTACK : ttsc_pkg::MODE_APPROACH;
            end else begin
                n_centered = 1'b0;
                n_close    = 1'b0;
                w_res.duty = i_cfg.duty_track;
                if (i_item.left_seen) begin
                    n_side          = ttsc_pkg::SIDE_LEFT;
                    w_res.drive_cmd = ttsc_pkg::CMD_LEFT;
                    w_res.mode      = ttsc_pkg::MODE_TRACK_L;
                end else begin
                    n_side          = ttsc_pkg::SIDE_RIGHT;
                    w_res.drive_cmd = ttsc_pkg::CMD_RIGHT;
                    w_res.mode      = ttsc_pkg::MODE_TRACK_R;
                end
            end
        end else if (w_in_hold) begin
            // Repeat the last decision.
            if (r_centered) begin
                w_res.drive_cmd = ttsc_pkg::CMD_FWD;
                w_res.duty = r_close ? i_cfg.duty_attack : i_cfg.duty_approach;
                w_res.mode = r_close ? ttsc_pkg::MODE_ATTACK : ttsc_pkg::MODE_APPROACH;
            end else if (r_side == ttsc_pkg::SIDE_LEFT) begin
                w_res.drive_cmd = ttsc_pkg::CMD_LEFT;
                w_res.duty      = i_cfg.duty_track;
                w_res.mode      = ttsc_pkg::MODE_TRACK_L;
            end else if (r_side == ttsc_pkg::SIDE_RIGHT) begin
                w_res.drive_cmd = ttsc_pkg::CMD_RIGHT;
                w_res.duty      = i_cfg.duty_track;
                w_res.mode      = ttsc_pkg::MODE_TRACK_R;
            end else begin
                w_res.drive_cmd = ttsc_pkg::CMD_FWD;
                w_res.duty      = i_cfg.duty_approach;
                w_res.mode      = ttsc_pkg::MODE_APPROACH;
            end
        end else begin
            case (r_phase)
                ttsc_pkg::PH_FWD: begin
                    w_res.drive_cmd = ttsc_pkg::CMD_FWD;
                    w_res.duty      = i_cfg.duty_search;
                    if (w_elapsed >= ttsc_pkg::TIME_BITS'(i_cfg.search_forward_ms)) begin
                        n_phase       = ttsc_pkg::PH_ROT;
                        n_phase_start = w_now;
                    end
                end
                default: begin
                    w_res.drive_cmd = (r_side == ttsc_pkg::SIDE_RIGHT)
                                    ? ttsc_pkg::CMD_RIGHT : ttsc_pkg::CMD_LEFT;
                    w_res.duty      = ttsc_pkg::DUTY_SEARCH_ROTATE;
                    if (w_elapsed >= ttsc_pkg::TIME_BITS'(i_cfg.search_rotate_ms)) begin
                        n_phase       = ttsc_pkg::PH_FWD;
                        n_phase_start = w_now;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ttsc_pkg::PH_ROT;
            r_phase_start <= '0;
            r_last_sight  <= '0;
            r_side        <= ttsc_pkg::SIDE_NONE;
            r_centered    <= 1'b0;
            r_close       <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_last_sight  <= n_last_sight;
            r_side        <= n_side;
            r_centered    <= n_centered;
            r_close       <= n_close;
        end
    end

    assign o_res = w_res;

endmodule

/* rtl/target_track_search_controller_core.sv */
// Channel   Dir  Modport  Payload                                          Beat when
// i_evt     in   sink     kind, now_ms, left/right_seen, left/right_dist   valid && ready
// o_res     out  source   drive_cmd, duty, mode                            valid && ready
// i_cfg_*   in   -        i_cfg_idx, i_cfg_wdata                           i_cfg_we
//
// One item per cycle sustained while no output stall holds the flow; the input beat loads
// the input register and the decision logic then loads the result register from it, so
// every result beat comes through both registers after its input beat.
// The tracking state updates as an item leaves the input register, so the next item
// sees it in the following cycle.
// Restart items update the search state and give no result beat.
// Synchronous active-low reset restores register defaults and the search state.
// An output stall backs up into the input register; i_evt.ready drops only when both hold.
module target_track_search_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ttsc_in_if.sink                           i_evt,
    ttsc_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    ttsc_pkg::t_cfg  w_cfg;
    ttsc_pkg::t_res  w_res;

    // Input register.
    logic            r_in_valid;
    ttsc_pkg::t_item r_in;

    // Result register.
    logic                        r_out_valid;
    logic [ttsc_pkg::CMD_W-1:0]  r_out_cmd;
    logic [ttsc_pkg::DUTY_W-1:0] r_out_duty;
    logic [ttsc_pkg::MODE_W-1:0] r_out_mode;

    logic w_out_free;
    logic w_adv;
    logic w_in_take;

    ttsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ttsc_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // The result register can take a new beat when empty or draining this cycle.
    assign w_out_free = !r_out_valid || o_res.ready;
    // Advance the held item when it emits nothing or its result has room.
    assign w_adv      = r_in_valid && (!w_res.emit || w_out_free);
    assign i_evt.ready = !r_in_valid || w_adv;
    assign w_in_take  = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.kind          <= i_evt.kind;
            r_in.now_ms        <= i_evt.now_ms;
            r_in.left_seen     <= i_evt.left_seen;
            r_in.right_seen    <= i_evt.right_seen;
            r_in.left_dist_cm  <= i_evt.left_dist_cm;
            r_in.right_dist_cm <= i_evt.right_dist_cm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.emit) begin
            r_out_cmd  <= w_res.drive_cmd;
            r_out_duty <= w_res.duty;
            r_out_mode <= w_res.mode;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.drive_cmd = r_out_cmd;
    assign o_res.duty      = r_out_duty;
    assign o_res.mode      = r_out_mode;

    // Input side stalls only while an item waits in the input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_evt.ready |-> r_in_valid)
        else $error("input stalled with empty input register");

    // A restart item leaving into a free result register adds no result beat.
    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.kind == ttsc_pkg::KIND_RESTART && w_out_free) |=> !r_out_valid)
        else $error("restart item produced a result");

    // A held item stays put until it advances.
    a_held_item_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input register changed");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !(w_adv && w_res.emit))
        else $error("result register overwritten while stalled");

endmodule
